// File: rtl/gbnws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbnws_pkg;

    // Window and retry limits; MAX_WINDOW must be a power of two (slot = low bits of seq)
    localparam int MAX_WINDOW  = 32;
    localparam int MAX_RETRY   = 5;
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int SEQ_W     = 16;
    localparam int WIN_W     = 6;
    localparam int RETRY_W   = 3;
    localparam int ACK_W     = 17;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Stream packing
    localparam int IN_TDATA_W   = ((ACK_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * SEQ_W + WIN_W + RETRY_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Reset values of the configuration registers
    localparam logic [WIN_W-1:0]   WINDOW_LIMIT_RESET = WIN_W'(8);
    localparam logic [SEQ_W-1:0]   TOTAL_SEG_RESET    = SEQ_W'(1);
    localparam logic [RETRY_W-1:0] RETRY_SAT          = '1;

    // Request codes on the input tuser
    localparam logic [REQ_W-1:0] REQ_SEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK  = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS = 2'd1;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TIMEOUT
    } op_t;

    typedef enum logic [1:0] {
        KIND_SEND  = 2'd0,
        KIND_ABORT = 2'd1,
        KIND_ACK   = 2'd2,
        KIND_FIN   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DECODE,
        B_SCAN,
        B_SEND,
        B_ABORT,
        B_CLEAR,
        B_ACKOUT,
        B_FIN
    } back_state_t;

    // Classified command passed from front to back
    typedef struct packed {
        op_t              op;
        logic             ack_ok;    // ack with a non-negative sequence number
        logic [ACK_W-1:0] ack_next;  // acked number plus one
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic [SEQ_W-1:0]   seq_num;
        logic [SEQ_W-1:0]   window_base;
        logic [WIN_W-1:0]   window_used;
        logic [RETRY_W-1:0] retry_count;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/go_back_n_window_sender.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: each request is popped from the queue and decoded; a send round of w segments
//   runs w retry checks first, then w sends, one per cycle on the single retry-counter
//   port while the result output is not stalled; an ack that advances the base clears
//   k = min(advance,32) retry slots before its ack result, and a trailing fin may follow.
// Results are registered, and each result stall holds the sequencer.
// Reset: base, abort flag and all retry counters clear at once; window_limit 8, total 1.

module go_back_n_window_sender
    import gbnws_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    // request stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [16:0] ack_seq, rest zero
    input  wire logic [REQ_W-1:0]       s_axis_tuser,  // [1:0] req_type
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [15:0] seq_num, [31:16] window_base,
                                                       // [37:32] window_used,
                                                       // [40:38] retry_count, rest zero
    output logic [1:0]                  m_axis_tuser,  // [1:0] kind
    output logic                        m_axis_tlast   // final result of a request
);

    logic    q_ready;
    logic    q_push;
    cmd_t    push_cmd;
    logic    q_valid;
    logic    q_pop;
    cmd_t    head_cmd;
    result_t res;

    // Front: classify each request transfer and push it into the command queue
    gbnws_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (s_axis_tuser),
        .in_ack   (s_axis_tdata[ACK_W-1:0]),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Short queue: lets requests land while the sequencer is still emitting
    gbnws_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_cmd),
        .ready (q_ready),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (head_cmd)
    );

    // Back: window state, retry counters and the result sequencer
    gbnws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the result fields, lowest field first, zero fill to whole bytes
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.retry_count, res.window_used,
                           res.window_base, res.seq_num};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// File: rtl/gbnws_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gbnws_front
    import gbnws_pkg::*;
(
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [REQ_W-1:0] in_req,
    input  wire logic [ACK_W-1:0] in_ack,
    input  wire logic             q_ready,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    always_comb
    begin
        unique case (in_req)
            REQ_SEND: q_cmd.op = OP_SEND;
            REQ_ACK:  q_cmd.op = OP_ACK;
            default:  q_cmd.op = OP_TIMEOUT;
        endcase
        // negative ack leaves the base alone
        q_cmd.ack_ok   = (in_req == REQ_ACK) && !in_ack[ACK_W-1];
        q_cmd.ack_next = {1'b0, in_ack[ACK_W-2:0]} + ACK_W'(1);
    end

endmodule

`default_nettype wire

// File: rtl/gbnws_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gbnws_queue
    import gbnws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t din,
    output logic      ready,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      dout
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gbnws_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gbnws_back
    import gbnws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 q_valid,
    input  wire cmd_t                 q_cmd,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output result_t                   out_res
);

    back_state_t        state_reg, state_next;
    logic [WIN_W-1:0]   limit_reg;
    logic [SEQ_W-1:0]   total_reg;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic               aborted_reg, aborted_next;
    logic [RETRY_W-1:0] cnt_reg [MAX_WINDOW];
    cmd_t               cmd_reg, cmd_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [WIN_W-1:0]   w_reg, w_next;
    logic [SEQ_W-1:0]   nb_reg, nb_next;
    logic [SEQ_W-1:0]   ab_seq_reg, ab_seq_next;
    logic [WIN_W-1:0]   ab_used_reg, ab_used_next;
    logic [RETRY_W-1:0] ab_cnt_reg, ab_cnt_next;
    logic               out_valid_reg;
    result_t            out_res_reg, res_next;
    logic               out_load, out_free;
    logic               cnt_we;
    logic [RETRY_W-1:0] cnt_wdata;

    logic [WIN_W-1:0]   lim_eff;
    logic [SEQ_W-1:0]   remaining;
    logic               none_left;
    logic [WIN_W-1:0]   eff_win;
    logic [SEQ_W-1:0]   cur_seq;
    logic [SLOT_W-1:0]  cur_slot;
    logic [RETRY_W-1:0] cur_cnt;
    logic               idx_last;
    logic [ACK_W-1:0]   nb_cand;
    logic [SEQ_W-1:0]   adv;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Effective window from the current base
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_eff = WIN_W'(1);
        end
        else if (limit_reg > WIN_W'(MAX_WINDOW))
        begin
            lim_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            lim_eff = limit_reg;
        end
        none_left = !(total_reg > base_reg);
        remaining = none_left ? '0 : total_reg - base_reg;
        eff_win   = (SEQ_W'(lim_eff) < remaining) ? lim_eff : remaining[WIN_W-1:0];
    end

    assign cur_seq  = base_reg + SEQ_W'(idx_reg);
    assign cur_slot = cur_seq[SLOT_W-1:0];
    assign cur_cnt  = cnt_reg[cur_slot];
    assign idx_last = (WIN_W'(idx_reg) == w_reg - WIN_W'(1));

    // New base after an ack, held within the transfer
    assign nb_cand = (cmd_reg.ack_next > {1'b0, total_reg}) ? {1'b0, total_reg}
                                                            : cmd_reg.ack_next;
    assign adv     = nb_cand[SEQ_W-1:0] - base_reg;

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        aborted_next = aborted_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        w_next       = w_reg;
        nb_next      = nb_reg;
        ab_seq_next  = ab_seq_reg;
        ab_used_next = ab_used_reg;
        ab_cnt_next  = ab_cnt_reg;
        q_pop        = 1'b0;
        out_load     = 1'b0;
        cnt_we       = 1'b0;
        cnt_wdata    = '0;
        res_next     = '{kind: KIND_FIN, seq_num: '0, window_base: base_reg,
                         window_used: '0, retry_count: '0, last: 1'b1};

        unique case (state_reg)
            B_IDLE:
            begin
                idx_next = '0;
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = B_DECODE;
                end
            end

            B_DECODE:
            begin
                if (aborted_reg)
                begin
                    ab_seq_next  = base_reg;
                    ab_used_next = eff_win;
                    ab_cnt_next  = cur_cnt;
                    state_next   = B_ABORT;
                end
                else if (cmd_reg.op == OP_SEND)
                begin
                    w_next     = eff_win;
                    state_next = (eff_win == '0) ? B_FIN : B_SCAN;
                end
                else if (cmd_reg.ack_ok && (nb_cand > {1'b0, base_reg}))
                begin
                    nb_next    = nb_cand[SEQ_W-1:0];
                    w_next     = (adv > SEQ_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                            : adv[WIN_W-1:0];
                    state_next = B_CLEAR;
                end
                else
                begin
                    state_next = B_ACKOUT;
                end
            end

            B_SCAN:
            begin
                if (cur_cnt > RETRY_W'(MAX_RETRY))
                begin
                    ab_seq_next  = cur_seq;
                    ab_used_next = w_reg;
                    ab_cnt_next  = cur_cnt;
                    idx_next     = '0;
                    state_next   = B_ABORT;
                end
                else if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = B_SEND;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            B_SEND:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    res_next = '{kind: KIND_SEND, seq_num: cur_seq, window_base: base_reg,
                                 window_used: w_reg, retry_count: cur_cnt, last: idx_last};
                    cnt_we    = (cur_cnt != RETRY_SAT);
                    cnt_wdata = cur_cnt + RETRY_W'(1);
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            B_ABORT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    res_next     = '{kind: KIND_ABORT, seq_num: ab_seq_reg,
                                     window_base: base_reg, window_used: ab_used_reg,
                                     retry_count: ab_cnt_reg, last: 1'b1};
                    aborted_next = 1'b1;
                    state_next   = B_IDLE;
                end
            end

            B_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = '0;
                if (idx_last)
                begin
                    idx_next   = '0;
                    base_next  = nb_reg;
                    state_next = B_ACKOUT;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            B_ACKOUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    res_next   = '{kind: KIND_ACK, seq_num: '0, window_base: base_reg,
                                   window_used: eff_win, retry_count: '0,
                                   last: !none_left};
                    state_next = none_left ? B_FIN : B_IDLE;
                end
            end

            B_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            limit_reg     <= WINDOW_LIMIT_RESET;
            total_reg     <= TOTAL_SEG_RESET;
            base_reg      <= '0;
            aborted_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            aborted_reg <= aborted_next;
            idx_reg     <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cnt_we)
            begin
                cnt_reg[cur_slot] <= cnt_wdata;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LIMIT:   limit_reg <= cfg_data[WIN_W-1:0];
                    CFG_TOTAL_SEGMENTS: total_reg <= cfg_data[SEQ_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        w_reg       <= w_next;
        nb_reg      <= nb_next;
        ab_seq_reg  <= ab_seq_next;
        ab_used_reg <= ab_used_next;
        ab_cnt_reg  <= ab_cnt_next;
        if (out_load)
        begin
            out_res_reg <= res_next;
        end
    end

    // An abort is sticky until reset
    a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg |=> aborted_reg)
        else $error("abort flag dropped");

    // A send never runs past the round's window
    a_send_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SEND) |-> (WIN_W'(idx_reg) < w_reg))
        else $error("send index outside window");

    // Clearing only happens ahead of a real base advance
    a_clear_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> (nb_reg > base_reg))
        else $error("clear pass without base advance");

    // The final result of an item returns the sequencer to idle
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_next.last) |=> (state_reg == B_IDLE))
        else $error("sequencer busy after final result");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gbnws_pkg::*;

    // Request codes with no name in the package
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SPARE   = 2'd3;
    localparam logic [ACK_W-1:0] ACK_NONE    = '1;

    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [16:0] ack_seq
    logic [REQ_W-1:0]       s_axis_tuser  = '0;   // [1:0] req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [15:0] seq, [31:16] base, [37:32] used,
                                                  // [40:38] retry
    logic [1:0]             m_axis_tuser;         // [1:0] kind
    logic                   m_axis_tlast;

    // Shadow copy of the sender state and its registers
    logic [WIN_W-1:0]   shadow_win_limit = WINDOW_LIMIT_RESET;
    logic [SEQ_W-1:0]   shadow_total     = TOTAL_SEG_RESET;
    logic [SEQ_W-1:0]   shadow_base      = '0;
    logic [RETRY_W-1:0] shadow_retry [MAX_WINDOW] = '{default: '0};
    bit                 shadow_aborted   = 1'b0;

    result_t pending_results [$];
    result_t want_result;
    int      fail_count  = 0;
    int      idle_cycles = 0;
    bit      no_idle     = 1'b0;

    go_back_n_window_sender i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic int retry_slot(int seq);
        return seq % MAX_WINDOW;
    endfunction

    function automatic int remaining_segments();
        return (shadow_total > shadow_base) ? int'(shadow_total) - int'(shadow_base) : 0;
    endfunction

    // Limit 0 behaves as 1, anything above the slot count is clipped to it
    function automatic int effective_window();
        int lim;
        int rem;
        lim = (shadow_win_limit == 0) ? 1 : int'(shadow_win_limit);
        rem = remaining_segments();
        if (lim > MAX_WINDOW)
            lim = MAX_WINDOW;
        return (lim < rem) ? lim : rem;
    endfunction

    // Offset in the window of the first segment past its retry budget, or -1
    function automatic int first_overdue_segment();
        int w;
        w = effective_window();
        for (int i = 0; i < w; i++)
            if (shadow_retry[retry_slot(int'(shadow_base) + i)] > MAX_RETRY)
                return i;
        return -1;
    endfunction

    function automatic void queue_result(kind_t kind, int seq, int base, int used,
                                         int retry, bit last);
        result_t r;
        r.kind        = kind;
        r.seq_num     = SEQ_W'(seq);
        r.window_base = SEQ_W'(base);
        r.window_used = WIN_W'(used);
        r.retry_count = RETRY_W'(retry);
        r.last        = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_request(logic [REQ_W-1:0] req, logic [ACK_W-1:0] ack);
        int w;
        int c;
        int s;
        int overdue;
        int next_base;
        int adv;
        int k;
        bit done;
        w = effective_window();
        if (shadow_aborted)
        begin
            queue_result(KIND_ABORT, shadow_base, shadow_base, w,
                         shadow_retry[retry_slot(shadow_base)], 1'b1);
            return;
        end
        if (req == REQ_SEND)
        begin
            if (w == 0)
            begin
                queue_result(KIND_FIN, 0, shadow_base, 0, 0, 1'b1);
                return;
            end
            overdue = first_overdue_segment();
            if (overdue >= 0)
            begin
                s = int'(shadow_base) + overdue;
                shadow_aborted = 1'b1;
                queue_result(KIND_ABORT, s, shadow_base, w, shadow_retry[retry_slot(s)], 1'b1);
                return;
            end
            for (int i = 0; i < w; i++)
            begin
                s = int'(shadow_base) + i;
                c = shadow_retry[retry_slot(s)];
                queue_result(KIND_SEND, s, shadow_base, w, c, i == w - 1);
                if (c < RETRY_SAT)
                    shadow_retry[retry_slot(s)] = RETRY_W'(c + 1);
            end
            return;
        end
        // Timeouts and the spare code leave the state alone
        if (req == REQ_ACK && !ack[ACK_W-1])
        begin
            next_base = int'(ack[ACK_W-2:0]) + 1;
            if (next_base > int'(shadow_total))
                next_base = shadow_total;
            if (next_base > int'(shadow_base))
            begin
                adv = next_base - int'(shadow_base);
                k   = (adv < MAX_WINDOW) ? adv : MAX_WINDOW;
                for (int j = 0; j < k; j++)
                    shadow_retry[retry_slot(int'(shadow_base) + j)] = '0;
                shadow_base = SEQ_W'(next_base);
            end
        end
        done = (remaining_segments() == 0);
        queue_result(KIND_ACK, 0, shadow_base, effective_window(), 0, !done);
        if (done)
            queue_result(KIND_FIN, 0, shadow_base, 0, 0, 1'b1);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic push_request(input logic [REQ_W-1:0] req, input logic [ACK_W-1:0] ack);
        while (!no_idle && $urandom_range(0, 99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(ack);
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(req, ack);
    endtask

    // Hold the request stream and wait for every predicted result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_WINDOW_LIMIT)
            shadow_win_limit = value[WIN_W-1:0];
        else if (idx == CFG_TOTAL_SEGMENTS)
            shadow_total = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Window limit with junk in the unused upper bits
    task automatic write_window_limit(input int lim);
        logic [CFG_W-1:0] value;
        value = CFG_W'($urandom());
        value[WIN_W-1:0] = WIN_W'(lim);
        write_register(CFG_WINDOW_LIMIT, value);
    endtask

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual kind %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                compare_field("kind", want_result.kind, m_axis_tuser);
                compare_field("seq_num", want_result.seq_num, m_axis_tdata[15:0]);
                compare_field("window_base", want_result.window_base, m_axis_tdata[31:16]);
                compare_field("window_used", want_result.window_used, m_axis_tdata[37:32]);
                compare_field("retry_count", want_result.retry_count, m_axis_tdata[40:38]);
                compare_field("last", want_result.last, m_axis_tlast);
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("go_back_n_window_sender regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Reset registers: window 8, one segment
    task automatic test_after_reset();
        push_request(REQ_SEND, '0);
        push_request(REQ_TIMEOUT, 17'h0abcd);
        push_request(REQ_ACK, ACK_NONE);
        push_request(REQ_SPARE, 17'h15555);
        push_request(REQ_ACK, '0);            // last segment acked: ack then fin
        push_request(REQ_SEND, 17'h0aaaa);    // nothing left: fin only
        push_request(REQ_ACK, 17'h0ffff);
    endtask

    task automatic test_window_extremes();
        settle_block();
        write_window_limit(0);
        write_register(CFG_TOTAL_SEGMENTS, 16'd40);
        push_request(REQ_SEND, '0);
        settle_block();
        write_window_limit(63);
        push_request(REQ_SEND, '0);
        settle_block();
        write_window_limit(MAX_WINDOW);
        push_request(REQ_SEND, '0);
        settle_block();
        write_window_limit(MAX_WINDOW + 1);
        push_request(REQ_SEND, '0);
        push_request(REQ_ACK, 17'd4);
        push_request(REQ_ACK, 17'd2);         // below the base
        push_request(REQ_ACK, 17'h10000);     // negative but not -1
        push_request(REQ_ACK, 17'h1fffe);
    endtask

    task automatic test_ack_extremes();
        push_request(REQ_ACK, 17'h0ffff);     // clipped to the segment count
        settle_block();
        write_register(CFG_TOTAL_SEGMENTS, 16'hffff);
        write_window_limit(8);
        push_request(REQ_SEND, 17'h1ffff);
        push_request(REQ_ACK, '0);
        push_request(REQ_TIMEOUT, 17'h1ffff);
    endtask

    task automatic random_request();
        int r;
        int w;
        logic [ACK_W-1:0] junk;
        r    = $urandom_range(0, 99);
        w    = effective_window();
        junk = ACK_W'($urandom());
        // Turn a round that would abort into an ack so the transfer keeps going
        if (r < 40 && first_overdue_segment() < 0)
            push_request(REQ_SEND, junk);
        else if (r < 75)
            push_request(REQ_ACK, ACK_W'(int'(shadow_base) - 1 + int'($urandom_range(0, w))));
        else if (r < 85)
            push_request(r[0] ? REQ_TIMEOUT : REQ_SPARE, junk);
        else if (r < 90)
            push_request(REQ_ACK, ACK_NONE);
        else if (r < 95)
            push_request(REQ_ACK, junk);
        else
            push_request(REQ_ACK, ACK_W'($urandom_range(0, shadow_base)));
    endtask

    task automatic test_random_traffic();
        int lim;
        int tot;
        for (int phase = 0; phase < 5; phase++)
        begin
            settle_block();
            no_idle = (phase == 2);
            case ($urandom_range(0, 5))
                0:       lim = 0;
                1:       lim = 1;
                2:       lim = MAX_WINDOW;
                3:       lim = 63;
                default: lim = $urandom_range(1, 40);
            endcase
            write_window_limit(lim);
            if (shadow_base > 0 && $urandom_range(0, 5) == 0)
                tot = $urandom_range(1, shadow_base);
            else
                tot = int'(shadow_base) + int'($urandom_range(1, 400));
            if (tot > 65535)
                tot = 65535;
            write_register(CFG_TOTAL_SEGMENTS, CFG_W'(tot));
            for (int n = 0; n < 30; n++)
            begin
                if (phase == 3 && n == 15)
                    drain_results();
                random_request();
            end
        end
        no_idle = 1'b0;
    endtask

    // Resend without acks until the budget runs out, then poke the stuck sender
    task automatic test_abort();
        int tot;
        settle_block();
        write_window_limit($urandom_range(2, 6));
        tot = int'(shadow_base) + 50;
        if (tot > 65535)
            tot = 65535;
        write_register(CFG_TOTAL_SEGMENTS, CFG_W'(tot));
        while (!shadow_aborted)
            push_request(REQ_SEND, ACK_W'($urandom()));
        repeat (5)
            push_request(REQ_W'($urandom_range(0, 3)), ACK_W'($urandom()));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_window_extremes();
        test_ack_extremes();
        test_random_traffic();
        test_abort();
        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("go_back_n_window_sender regression: pass");
        else
            $display("go_back_n_window_sender regression: fail");
        $finish;
    end

endmodule
